FILE: rtl/tcfp_pkg.sv
// Package: character codes, result type and digit arithmetic for the frame parser.
`default_nettype none

package tcfp_pkg;

  localparam int FRAME_MAX_DEF = 128;
  localparam int SLOT_COUNT    = 5;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_ZERO  = 8'd48;

  localparam int          MAG_W   = 17;
  localparam logic [16:0] MAG_CAP = 17'd100000;

  typedef struct packed {
    logic               updated;
    logic [2:0]         slot;
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic               slot0_cleared;
  } result_t;

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= CH_ZERO) && (b <= CH_ZERO + 8'd9);
  endfunction

  function automatic logic [MAG_W-1:0] mag_step(input logic [MAG_W-1:0] mag,
                                                input logic [7:0] b);
    logic [20:0] t;
    t = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {13'd0, b - CH_ZERO};
    mag_step = (t > {4'd0, MAG_CAP}) ? MAG_CAP : t[MAG_W-1:0];
  endfunction

  function automatic logic [15:0] to_s16(input logic [MAG_W-1:0] mag, input logic neg);
    logic [MAG_W-1:0] m;
    if (neg) begin
      m = (mag > 17'd32768) ? 17'd32768 : mag;
      to_s16 = 16'(17'd0 - m);
    end else begin
      m = (mag > 17'd32767) ? 17'd32767 : mag;
      to_s16 = m[15:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tcfp_parser.sv
// Frame parser: per-frame phase, digit accumulators and frame end detection.
`default_nettype none

module tcfp_parser #(
  parameter int FRAME_MAX = tcfp_pkg::FRAME_MAX_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire logic [7:0]       rx_byte,
  output tcfp_pkg::result_t     res
);

  localparam int LEN_W = $clog2(FRAME_MAX + 1);
  localparam int MW    = tcfp_pkg::MAG_W;

  localparam logic [3:0] P_OPEN   = 4'd0;
  localparam logic [3:0] P_SIGN   = 4'd1;
  localparam logic [3:0] P_XFIRST = 4'd2;
  localparam logic [3:0] P_XRUN   = 4'd3;
  localparam logic [3:0] P_SPACE  = 4'd4;
  localparam logic [3:0] P_NOSP   = 4'd5;
  localparam logic [3:0] P_YSIGN  = 4'd6;
  localparam logic [3:0] P_YRUN   = 4'd7;
  localparam logic [3:0] P_YEND   = 4'd8;
  localparam logic [3:0] P_BAD    = 4'd9;

  logic [LEN_W-1:0] len_r, len_nxt, len_inc;
  logic [3:0]       phase_r, phase_nxt, phase_adv;
  logic [7:0]       prev_r, prev_nxt;
  logic             b5n_r, b5n_nxt, b5n_adv;
  logic             xneg_r, xneg_nxt, yneg_r, yneg_nxt;
  logic [MW-1:0]    xmag_r, xmag_nxt, ymag_r, ymag_nxt;
  logic             dig, frame_end, good, space_ok, restart;
  logic [7:0]       tag;

  always_comb begin
    dig       = tcfp_pkg::is_digit(rx_byte);
    phase_adv = phase_r;
    xneg_nxt  = xneg_r;
    yneg_nxt  = yneg_r;
    xmag_nxt  = xmag_r;
    ymag_nxt  = ymag_r;
    case (phase_r)
      P_OPEN: begin
        phase_adv = (rx_byte == tcfp_pkg::CH_OPEN) ? P_SIGN : P_BAD;
      end
      P_SIGN: begin
        if (dig) begin
          phase_adv = P_XRUN;
          xneg_nxt  = 1'b0;
          xmag_nxt  = tcfp_pkg::mag_step('0, rx_byte);
        end else if (rx_byte == tcfp_pkg::CH_MINUS) begin
          phase_adv = P_XFIRST;
          xneg_nxt  = 1'b1;
        end else begin
          phase_adv = P_BAD;
        end
      end
      P_XFIRST: begin
        if (dig) begin
          phase_adv = P_XRUN;
          xmag_nxt  = tcfp_pkg::mag_step('0, rx_byte);
        end else begin
          phase_adv = P_BAD;
        end
      end
      P_XRUN: begin
        if (dig) xmag_nxt = tcfp_pkg::mag_step(xmag_r, rx_byte);
        else phase_adv = P_SPACE;
      end
      P_SPACE: begin
        if (rx_byte == tcfp_pkg::CH_SPACE) begin
          phase_adv = P_YSIGN;
          yneg_nxt  = 1'b0;
          ymag_nxt  = '0;
        end else begin
          phase_adv = P_NOSP;
        end
      end
      P_YSIGN: begin
        if (rx_byte == tcfp_pkg::CH_MINUS) begin
          phase_adv = P_YRUN;
          yneg_nxt  = 1'b1;
        end else if (dig) begin
          phase_adv = P_YRUN;
          ymag_nxt  = tcfp_pkg::mag_step('0, rx_byte);
        end else begin
          phase_adv = P_YEND;
        end
      end
      P_YRUN: begin
        if (dig) ymag_nxt = tcfp_pkg::mag_step(ymag_r, rx_byte);
        else phase_adv = P_YEND;
      end
      default: begin
        phase_adv = phase_r;
      end
    endcase

    len_inc   = len_r + LEN_W'(1);
    b5n_adv   = b5n_r | ((len_r == LEN_W'(5)) && (rx_byte == tcfp_pkg::CH_N));
    tag       = prev_r - tcfp_pkg::CH_ZERO;
    frame_end = (rx_byte == tcfp_pkg::CH_CLOSE) && (len_r != '0) &&
                (prev_r >= tcfp_pkg::CH_ZERO) &&
                (prev_r < tcfp_pkg::CH_ZERO + 8'(tcfp_pkg::SLOT_COUNT));
    good      = (phase_adv != P_OPEN) && (phase_adv != P_SIGN) &&
                (phase_adv != P_XFIRST) && (phase_adv != P_BAD);
    space_ok  = (phase_adv == P_YSIGN) || (phase_adv == P_YRUN) || (phase_adv == P_YEND);
    restart   = frame_end || (len_inc >= LEN_W'(FRAME_MAX));

    res.updated       = frame_end && good;
    res.slot          = res.updated ? tag[2:0] : 3'd0;
    res.x_value       = (res.updated && space_ok) ? tcfp_pkg::to_s16(xmag_nxt, xneg_nxt) : '0;
    res.y_value       = (res.updated && space_ok) ? tcfp_pkg::to_s16(ymag_nxt, yneg_nxt) : '0;
    res.slot0_cleared = b5n_adv;

    len_nxt   = restart ? '0 : len_inc;
    phase_nxt = restart ? P_OPEN : phase_adv;
    b5n_nxt   = restart ? 1'b0 : b5n_adv;
    prev_nxt  = rx_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      phase_r <= P_OPEN;
      b5n_r   <= 1'b0;
    end else if (fire) begin
      len_r   <= len_nxt;
      phase_r <= phase_nxt;
      b5n_r   <= b5n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      prev_r <= prev_nxt;
      xneg_r <= xneg_nxt;
      yneg_r <= yneg_nxt;
      xmag_r <= xmag_nxt;
      ymag_r <= ymag_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tcfp_out_stage.sv
// Result register with skid entry: holds each result item until the sink takes it.
`default_nettype none

module tcfp_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire tcfp_pkg::result_t in_res,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tcfp_pkg::result_t  out_res
);

  logic              main_v_r, main_v_nxt, skid_v_r, skid_v_nxt;
  tcfp_pkg::result_t main_r, main_nxt, skid_r, skid_nxt;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (out_ready || !main_v_r) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = 1'b0;
      end else if (in_fire) begin
        main_nxt   = in_res;
        main_v_nxt = 1'b1;
      end else begin
        main_v_nxt = 1'b0;
      end
    end else if (in_fire) begin
      skid_nxt   = in_res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign in_ready  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_res   = main_r;

endmodule

`default_nettype wire

FILE: rtl/tagged_coordinate_frame_parser_core.sv
// Top level of the tagged coordinate frame parser.
// Takes one received byte per item and gives one result item per byte. Each
// byte is parsed in the cycle it is accepted and its result is registered. A
// new byte can be taken every cycle while in_ready is high. in_ready comes
// straight from the skid entry of the result register: it drops when a byte
// is taken while the sink stalls with one result already held, and rises
// again once the sink takes a result.
// A frame "(x<delim> y...<tag>)" with tag below five rewrites a slot and
// raises out_updated; out_slot0_cleared flags the sixth byte of a frame being 'n'.
`default_nettype none

module tagged_coordinate_frame_parser_core #(
  parameter int FRAME_MAX = tcfp_pkg::FRAME_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_updated,
  output logic [2:0]       out_slot,
  output logic signed [15:0] out_x_value,
  output logic signed [15:0] out_y_value,
  output logic             out_slot0_cleared
);

  logic              in_fire;
  tcfp_pkg::result_t parse_res, out_res;

  assign in_fire = in_valid && in_ready;

  tcfp_parser #(
    .FRAME_MAX(FRAME_MAX)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .rx_byte (in_rx_byte),
    .res     (parse_res)
  );

  tcfp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_res    (parse_res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_updated       = out_res.updated;
  assign out_slot          = out_res.slot;
  assign out_x_value       = out_res.x_value;
  assign out_y_value       = out_res.y_value;
  assign out_slot0_cleared = out_res.slot0_cleared;

endmodule

`default_nettype wire
